>>> hdl/clutd_pkg.sv
// clutd_pkg: shared types, codes and color helpers for the clut texture decoder
// used by clutd_lane, clutd_merge and the core; depends on nothing else
package clutd_pkg;

  localparam int LANES = 4;

  localparam logic OP_PAL_WRITE = 1'b0;
  localparam logic OP_TEXTURE   = 1'b1;

  localparam logic [15:0] TEXEL_OPAQUE = 16'h8000;

  typedef enum logic [1:0] {
    MODE_NIB4   = 2'd0,
    MODE_BYTE8  = 2'd1,
    MODE_DIRECT = 2'd2
  } mode_t;

  // per texture word control handed to the merge stage
  typedef struct packed {
    logic [1:0]  last_pos;
    logic        direct;
    logic [15:0] direct_texel;
  } word_meta_t;

  // bgr555 -> rgb555, bit 15 kept
  function automatic logic [15:0] bgr_to_rgb(input logic [15:0] w);
    return {w[15], w[4:0], w[9:5], w[14:10]};
  endfunction

  // zero stays transparent, anything else gets bit 15
  function automatic logic [15:0] make_texel(input logic [15:0] c);
    return (c == 16'h0000) ? 16'h0000 : (c | TEXEL_OPAQUE);
  endfunction

  // x mod depth for depth of 16 or more, by four restoring steps
  function automatic logic [7:0] wrap_index(input logic [7:0] x, input logic [8:0] depth);
    logic [11:0] r;
    logic [11:0] d;
    r = {4'b0000, x};
    for (int k = 3; k >= 0; k--) begin
      d = {3'b000, depth} << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[7:0];
  endfunction

endpackage

>>> hdl/clutd_ram.sv
// clutd_ram: generic single write port ram with registered read
// no dependencies
module clutd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/clutd_lane.sv
// clutd_lane: one decode lane with its own palette copy, picks its index and looks it up
// depends on clutd_pkg and clutd_ram
module clutd_lane #(
  parameter int LANE  = 0,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [15:0]              wr_data,
  input  logic                     rd_en,
  input  logic [15:0]              word,
  input  clutd_pkg::mode_t         mode,
  output logic [15:0]              texel
);
  import clutd_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;
  logic [7:0]    byte_idx;

  assign byte_idx = wrap_index(word[8*(LANE%2) +: 8], 9'(DEPTH));

  always_comb begin
    unique case (mode)
      MODE_BYTE8: rd_addr = byte_idx[AW-1:0];
      default:    rd_addr = AW'(word[4*LANE +: 4]);
    endcase
  end

  clutd_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_pal (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign texel = make_texel(rd_data);

endmodule

>>> hdl/clutd_merge.sv
// clutd_merge: holds one looked-up word, then serializes lane texels one per cycle
// while m_axis_tready is high; depends on clutd_pkg
module clutd_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  clutd_pkg::word_meta_t load_meta,
  input  logic [15:0]           lane_texel [clutd_pkg::LANES],
  output logic                  in_ready,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata, // texel
  output logic                  m_axis_tlast
);
  import clutd_pkg::*;

  logic        s1_valid;
  word_meta_t  s1_meta;
  logic        ser_valid;
  logic [15:0] ser_buf [LANES];
  logic [1:0]  pos;
  logic [1:0]  last_pos;
  logic        at_last;
  logic        advance;

  assign at_last  = (pos == last_pos);
  // lane read data is still registered in the rams while s1 holds
  assign advance  = s1_valid && (!ser_valid || (m_axis_tready && at_last));
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      ser_valid <= 1'b0;
      pos       <= 2'd0;
      last_pos  <= 2'd0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        ser_valid <= 1'b1;
        pos       <= 2'd0;
        last_pos  <= s1_meta.last_pos;
      end else if (ser_valid && m_axis_tready) begin
        if (at_last) begin
          ser_valid <= 1'b0;
        end else begin
          pos <= pos + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_meta <= load_meta;
    end
    if (advance) begin
      for (int i = 0; i < LANES; i++) begin
        if (i == 0 && s1_meta.direct) begin
          ser_buf[i] <= s1_meta.direct_texel;
        end else begin
          ser_buf[i] <= lane_texel[i];
        end
      end
    end
  end

  assign m_axis_tvalid = ser_valid;
  assign m_axis_tdata  = ser_buf[pos];
  assign m_axis_tlast  = at_last;

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    ser_valid |-> (pos <= last_pos))
    else $error("serializer position past last texel");

  a_advance_restarts: assert property (@(posedge clk) disable iff (rst)
    advance |=> (ser_valid && pos == 2'd0))
    else $error("serializer did not restart on new word");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (ser_valid && !m_axis_tready) |=> (ser_valid && $stable(pos)))
    else $error("serializer moved while output stalled");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    load |-> in_ready)
    else $error("word loaded while stage full");

endmodule

>>> hdl/clut_texture_page_decoder_core.sv
// clut_texture_page_decoder_core: four lanes look up palette entries in parallel,
// a merge stage sends texels out one per cycle while m_axis_tready is high. depends on
// clutd_pkg, clutd_lane, clutd_merge. a texture word is read from the lane palette rams,
// then registered in the serializer buffer that gives the first texel. 4, 2 or 1 texels
// per texture word in modes 0, 1, 2, and a palette write does not hold the input stream
// reset clears handshake state and color_mode to 0; palette contents stay undefined
module clut_texture_page_decoder_core #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata, // palette_index[7:0], data_word[23:8]
  input  logic        s_axis_tuser, // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata, // texel
  output logic        m_axis_tlast, // last_texel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data      // color_mode
);
  import clutd_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  mode_t      color_mode;
  logic       in_acc;
  logic       pal_wr;
  logic       tex_rd;
  logic [7:0] wr_idx;
  logic [15:0] word;
  logic       load;
  word_meta_t load_meta;
  logic [15:0] lane_texel [LANES];
  logic       in_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= MODE_NIB4;
    end else if (cfg_valid) begin
      color_mode <= mode_t'(cfg_data);
    end
  end

  assign s_axis_tready = in_ready;
  assign in_acc = s_axis_tvalid && in_ready;
  assign word   = s_axis_tdata[23:8];
  assign pal_wr = in_acc && (s_axis_tuser == OP_PAL_WRITE);
  assign tex_rd = in_acc && (s_axis_tuser == OP_TEXTURE);
  assign wr_idx = wrap_index(s_axis_tdata[7:0], 9'(PALETTE_DEPTH));

  always_comb begin
    load_meta.direct       = 1'b0;
    load_meta.direct_texel = make_texel(bgr_to_rgb(word));
    load_meta.last_pos     = 2'd0;
    load                   = 1'b0;
    unique case (color_mode)
      MODE_NIB4: begin
        load_meta.last_pos = 2'd3;
        load               = tex_rd;
      end
      MODE_BYTE8: begin
        load_meta.last_pos = 2'd1;
        load               = tex_rd;
      end
      MODE_DIRECT: begin
        load_meta.direct = 1'b1;
        load             = tex_rd;
      end
      default: begin
        // reserved mode: word is taken and dropped
        load = 1'b0;
      end
    endcase
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    clutd_lane #(
      .LANE (g),
      .DEPTH(PALETTE_DEPTH)
    ) u_lane (
      .clk    (clk),
      .wr_en  (pal_wr),
      .wr_addr(wr_idx[AW-1:0]),
      .wr_data(bgr_to_rgb(word)),
      .rd_en  (load),
      .word   (word),
      .mode   (color_mode),
      .texel  (lane_texel[g])
    );
  end

  clutd_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .load_meta    (load_meta),
    .lane_texel   (lane_texel),
    .in_ready     (in_ready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
